>>> src/branch_next_pc_unit_defines.svh
// Assertion macros for the branch next-PC unit.
// BPC_ASSERT:     checked property, off while reset is asserted.
// BPC_ASSERT_RST: checked property, also during reset.
`ifndef BRANCH_NEXT_PC_UNIT_DEFINES_SVH
`define BRANCH_NEXT_PC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BPC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPC_ASSERT(lbl, clk, rstn, prop, msg)
`define BPC_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

>>> src/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned INSTR_W = 32;
  localparam int unsigned PC_W    = 64;

  // bits 31:30
  localparam logic [1:0] KIND_UNCOND = 2'd0;
  localparam logic [1:0] KIND_COND   = 2'd1;
  localparam logic [1:0] KIND_REG    = 2'd3;
  localparam int unsigned KIND_LSB   = 30;

  // bits 3:0 of a conditional branch
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_GE = 4'b1010;
  localparam logic [3:0] COND_LT = 4'b1011;
  localparam logic [3:0] COND_GT = 4'b1100;
  localparam logic [3:0] COND_LE = 4'b1101;
  localparam logic [3:0] COND_AL = 4'b1110;

  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_COND = 2'd1,
    FAULT_KIND = 2'd2
  } fault_t;

  // one captured input word
  typedef struct packed {
    logic [INSTR_W-1:0] instr_word;
    logic [PC_W-1:0]    current_pc;
    logic [PC_W-1:0]    reg_value;
    logic               flag_n;
    logic               flag_z;
    logic               flag_v;
  } item_t;

endpackage

>>> src/bpc_if.sv
interface bpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpc_pkg::INSTR_W-1:0]  instr_word;
  logic [bpc_pkg::PC_W-1:0]     current_pc;
  logic [bpc_pkg::PC_W-1:0]     reg_value;
  logic                         flag_n;
  logic                         flag_z;
  logic                         flag_v;

  modport source (output valid, instr_word, current_pc, reg_value, flag_n, flag_z, flag_v,
                  input ready);
  modport sink   (input valid, instr_word, current_pc, reg_value, flag_n, flag_z, flag_v,
                  output ready);
endinterface

interface bpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpc_pkg::PC_W-1:0]  next_pc;
  logic                      taken;
  logic [1:0]                fault_code;

  modport source (output valid, next_pc, taken, fault_code, input ready);
  modport sink   (input valid, next_pc, taken, fault_code, output ready);
endinterface

>>> src/branch_next_pc_unit.sv
// Channel  Dir  Word
// in_ch    in   instr_word, current_pc, reg_value, flag_n, flag_z, flag_v
// out_ch   out  next_pc, taken, fault_code
//
// Result is registered: an accepted word passes through the input register, then the result register;
// one word per cycle sustained while out_ch does not stall.
// Path: input register -> decode, condition test and one 64-bit add -> result register.
// Reset (rst_n, synchronous, low) empties both registers; payload is not cleared.
// A stall on out_ch fills the input register, then drops in_ch.ready; both sides
// can move in the same cycle, so no bubble is lost under back-pressure.
`include "branch_next_pc_unit_defines.svh"

module branch_next_pc_unit (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch
);
  import bpc_pkg::*;

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  item_t              s1_item_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [PC_W-1:0]    out_next_pc_r, out_next_pc_nxt;
  logic               out_taken_r, out_taken_nxt;
  fault_t             out_fault_r, out_fault_nxt;

  logic               in_accept;
  logic               res_free;
  logic               res_load;

  // decode
  logic [1:0]         kind;
  logic [3:0]         cond;
  logic               cond_known;
  logic               cond_met;
  logic [PC_W-1:0]    off_uncond;
  logic [PC_W-1:0]    off_cond;
  logic [PC_W-1:0]    addend;
  logic [PC_W-1:0]    pc_sum;

  // handshake: result register frees when empty or being drained
  assign res_free    = !out_valid_r || out_ch.ready;
  assign res_load    = s1_valid_r && res_free;
  assign in_ch.ready = !s1_valid_r || res_free;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (res_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.instr_word <= in_ch.instr_word;
      s1_item_r.current_pc <= in_ch.current_pc;
      s1_item_r.reg_value  <= in_ch.reg_value;
      s1_item_r.flag_n     <= in_ch.flag_n;
      s1_item_r.flag_z     <= in_ch.flag_z;
      s1_item_r.flag_v     <= in_ch.flag_v;
    end
  end

  assign kind = s1_item_r.instr_word[KIND_LSB +: 2];
  assign cond = s1_item_r.instr_word[3:0];

  // imm26 and imm19, sign-extended and scaled by four
  assign off_uncond = {{(PC_W-28){s1_item_r.instr_word[25]}},
                       s1_item_r.instr_word[25:0], 2'b00};
  assign off_cond   = {{(PC_W-21){s1_item_r.instr_word[23]}},
                       s1_item_r.instr_word[23:5], 2'b00};

  // GE/LT use N==V / N!=V
  always_comb begin
    cond_known = 1'b1;
    cond_met   = 1'b0;
    case (cond)
      COND_EQ: cond_met = s1_item_r.flag_z;
      COND_NE: cond_met = !s1_item_r.flag_z;
      COND_GE: cond_met = (s1_item_r.flag_n == s1_item_r.flag_v);
      COND_LT: cond_met = (s1_item_r.flag_n != s1_item_r.flag_v);
      COND_GT: cond_met = !s1_item_r.flag_z && (s1_item_r.flag_n == s1_item_r.flag_v);
      COND_LE: cond_met = !(!s1_item_r.flag_z && (s1_item_r.flag_n == s1_item_r.flag_v));
      COND_AL: cond_met = 1'b1;
      default: cond_known = 1'b0;
    endcase
  end

  // single shared adder; the addend is chosen by kind and condition
  always_comb begin
    if (kind == KIND_UNCOND) begin
      addend = off_uncond;
    end else if (cond_met) begin
      addend = off_cond;
    end else begin
      addend = PC_W'(4);
    end
  end

  assign pc_sum = s1_item_r.current_pc + addend;

  always_comb begin
    out_next_pc_nxt = s1_item_r.current_pc;
    out_taken_nxt   = 1'b0;
    out_fault_nxt   = FAULT_OK;
    case (kind)
      KIND_UNCOND: begin
        out_next_pc_nxt = pc_sum;
        out_taken_nxt   = 1'b1;
      end
      KIND_REG: begin
        out_next_pc_nxt = s1_item_r.reg_value;
        out_taken_nxt   = 1'b1;
      end
      KIND_COND: begin
        if (!cond_known) begin
          out_fault_nxt = FAULT_COND;
        end else begin
          out_next_pc_nxt = pc_sum;
          out_taken_nxt   = cond_met;
        end
      end
      default: out_fault_nxt = FAULT_KIND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_next_pc_r <= out_next_pc_nxt;
      out_taken_r   <= out_taken_nxt;
      out_fault_r   <= out_fault_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_pc    = out_next_pc_r;
  assign out_ch.taken      = out_taken_r;
  assign out_ch.fault_code = out_fault_r;

  // a faulting word never redirects
  `BPC_ASSERT(a_fault_not_taken, clk, rst_n, (out_valid_r && out_fault_r != FAULT_OK) |-> !out_taken_r, "fault with taken set")
  // a loaded word appears on the output next cycle
  `BPC_ASSERT(a_load_shows, clk, rst_n, res_load |=> out_valid_r, "loaded word lost")
  // input register cannot be overwritten while its word is still held
  `BPC_ASSERT(a_no_overwrite, clk, rst_n, (s1_valid_r && !res_free) |-> !in_ch.ready, "input register overrun")
  // reset empties the pipe
  `BPC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipe not empty after reset")

endmodule
